// ----- hdl/c_subset_lexer_defines.svh -----
// ----------------------------------------------------------------------------
// c_subset_lexer_defines.svh
// Assertion macros shared by the lexer checker
// ----------------------------------------------------------------------------
`ifndef C_SUBSET_LEXER_DEFINES_SVH
`define C_SUBSET_LEXER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define CSLEX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define CSLEX_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/cslex_pkg.sv -----
// ----------------------------------------------------------------------------
// cslex_pkg
// Token codes, character classes and keyword table for the C subset lexer
// ----------------------------------------------------------------------------
`default_nettype none

package cslex_pkg;

  localparam int NAME_CHARS_KEPT_DEF = 8;
  localparam int OUTQ_DEPTH          = 4;
  localparam int TDATA_W             = 104;
  localparam int NUM_KEYWORDS        = 7;

  // token kinds
  localparam logic [4:0] KIND_EOF       = 5'd0;
  localparam logic [4:0] KIND_FOR       = 5'd1;
  localparam logic [4:0] KIND_IDENT     = 5'd8;
  localparam logic [4:0] KIND_NUMBER    = 5'd9;
  localparam logic [4:0] KIND_PLUS      = 5'd10;
  localparam logic [4:0] KIND_PLUSPLUS  = 5'd11;
  localparam logic [4:0] KIND_MINUS     = 5'd12;
  localparam logic [4:0] KIND_STAR      = 5'd13;
  localparam logic [4:0] KIND_AMP       = 5'd14;
  localparam logic [4:0] KIND_ASSIGN    = 5'd15;
  localparam logic [4:0] KIND_EQEQ      = 5'd16;
  localparam logic [4:0] KIND_LT        = 5'd17;
  localparam logic [4:0] KIND_GT        = 5'd18;
  localparam logic [4:0] KIND_LPAREN    = 5'd19;
  localparam logic [4:0] KIND_RPAREN    = 5'd20;
  localparam logic [4:0] KIND_LBRACE    = 5'd21;
  localparam logic [4:0] KIND_RBRACE    = 5'd22;
  localparam logic [4:0] KIND_SEMI      = 5'd23;
  localparam logic [4:0] KIND_COMMA     = 5'd24;
  localparam logic [4:0] KIND_LBRACKET  = 5'd25;
  localparam logic [4:0] KIND_RBRACKET  = 5'd26;
  localparam logic [4:0] KIND_ERROR     = 5'd27;

  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_NINE  = "9";
  localparam logic [7:0] CH_UNDER = "_";
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_EQ    = "=";

  // keyword text, first character in the lowest byte
  localparam logic [63:0] KW_TEXT [NUM_KEYWORDS] = '{
    64'h0000_0000_0072_6f66,  // for
    64'h0000_0065_6c69_6877,  // while
    64'h0000_0000_0000_6669,  // if
    64'h0000_0000_6573_6c65,  // else
    64'h0000_0000_0074_6e69,  // int
    64'h0000_0000_7469_7274,  // trit
    64'h0000_6e72_7574_6572   // return
  };
  localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{
    4'd3, 4'd5, 4'd2, 4'd4, 4'd3, 4'd4, 4'd6
  };

  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] value;
    logic [63:0] chars;
    logic [3:0]  length;
    logic        last;
  } token_t;

  typedef struct packed {
    logic [1:0] count;
    token_t     tok1;
    token_t     tok0;
  } cslex_res_t;

  localparam token_t TOKEN_NONE = '0;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // single-character punctuation, anything else maps to error
  function automatic logic [4:0] single_kind(input logic [7:0] c);
    logic [4:0] k;
    case (c)
      "-":     k = KIND_MINUS;
      "*":     k = KIND_STAR;
      "&":     k = KIND_AMP;
      "<":     k = KIND_LT;
      ">":     k = KIND_GT;
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      "{":     k = KIND_LBRACE;
      "}":     k = KIND_RBRACE;
      ";":     k = KIND_SEMI;
      ",":     k = KIND_COMMA;
      "[":     k = KIND_LBRACKET;
      "]":     k = KIND_RBRACKET;
      default: k = KIND_ERROR;
    endcase
    return k;
  endfunction

  // keyword kind on exact length match, eof code when none matches
  function automatic logic [4:0] keyword_kind(input logic [63:0] chars,
                                              input logic [3:0]  len);
    logic [4:0] k;
    k = KIND_EOF;
    for (int i = 0; i < NUM_KEYWORDS; i++) begin
      if (len == KW_LEN[i] && chars == KW_TEXT[i]) k = KIND_FOR + 5'(i);
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/cslex_core.sv -----
// ----------------------------------------------------------------------------
// cslex_core
// Lexer state and single-pass token decode for one character word
// ----------------------------------------------------------------------------
`default_nettype none

module cslex_core #(
  parameter int NAME_CHARS_KEPT = cslex_pkg::NAME_CHARS_KEPT_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_fire,
  input  wire logic [7:0]           in_char,
  input  wire logic                 in_end,
  output cslex_pkg::cslex_res_t     res
);
  import cslex_pkg::*;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_IDENT  = 3'd1,
    MODE_NUMBER = 3'd2,
    MODE_PLUS   = 3'd3,
    MODE_EQ     = 3'd4,
    MODE_ERROR  = 3'd5
  } mode_t;

  mode_t       mode, mode_next;
  logic [7:0]  nbuf [NAME_CHARS_KEPT];
  logic [7:0]  nbuf_next [NAME_CHARS_KEPT];
  logic [3:0]  nlen, nlen_next;
  logic [31:0] acc, acc_next;
  logic [63:0] nchars;
  logic [4:0]  kw;
  logic [4:0]  sk;
  logic        flush_vld;
  token_t      flush_tok;
  token_t      tok0, tok1;
  token_t      start_tok;
  logic [1:0]  cnt;

  // pack kept name characters into the 64-bit field
  always_comb begin
    nchars = '0;
    for (int i = 0; i < NAME_CHARS_KEPT; i++) nchars[8*i +: 8] = nbuf[i];
  end

  assign kw = keyword_kind(nchars, nlen);
  assign sk = single_kind(in_char);

  // token held in the current mode, emitted when the mode ends
  always_comb begin
    flush_vld = 1'b0;
    flush_tok = TOKEN_NONE;
    case (mode)
      MODE_IDENT: begin
        flush_vld = 1'b1;
        if (kw != KIND_EOF) begin
          flush_tok.kind = kw;
        end else begin
          flush_tok.kind   = KIND_IDENT;
          flush_tok.chars  = nchars;
          flush_tok.length = (nlen > 4'(NAME_CHARS_KEPT)) ? 4'(NAME_CHARS_KEPT) : nlen;
        end
      end
      MODE_NUMBER: begin
        flush_vld       = 1'b1;
        flush_tok.kind  = KIND_NUMBER;
        flush_tok.value = acc;
      end
      MODE_PLUS: begin
        flush_vld      = 1'b1;
        flush_tok.kind = KIND_PLUS;
      end
      MODE_EQ: begin
        flush_vld      = 1'b1;
        flush_tok.kind = KIND_ASSIGN;
      end
      default: begin
        flush_vld = 1'b0;
      end
    endcase
  end

  // token from a character that opens nothing longer
  always_comb begin
    start_tok       = TOKEN_NONE;
    start_tok.kind  = sk;
    start_tok.value = (sk == KIND_ERROR) ? {24'd0, in_char} : 32'd0;
  end

  // next state and up to two tokens
  always_comb begin
    mode_next = mode;
    nbuf_next = nbuf;
    nlen_next = nlen;
    acc_next  = acc;
    tok0      = TOKEN_NONE;
    tok1      = TOKEN_NONE;
    cnt       = 2'd0;
    if (in_end) begin
      mode_next = MODE_IDLE;
      for (int i = 0; i < NAME_CHARS_KEPT; i++) nbuf_next[i] = 8'd0;
      nlen_next = 4'd0;
      acc_next  = 32'd0;
      if (mode != MODE_ERROR && flush_vld) begin
        tok0      = flush_tok;
        tok1      = TOKEN_NONE;
        tok1.kind = KIND_EOF;
        cnt       = 2'd2;
      end else begin
        tok0.kind = KIND_EOF;
        cnt       = 2'd1;
      end
    end else if (mode == MODE_ERROR) begin
      cnt = 2'd0;
    end else if (mode == MODE_IDENT && (is_alpha(in_char) || is_digit(in_char))) begin
      for (int i = 0; i < NAME_CHARS_KEPT; i++) begin
        if (nlen == 4'(i)) nbuf_next[i] = in_char;
      end
      if (nlen < 4'd9) nlen_next = nlen + 4'd1;
    end else if (mode == MODE_NUMBER && is_digit(in_char)) begin
      acc_next = (acc << 3) + (acc << 1) + {24'd0, in_char - CH_ZERO};
    end else if (mode == MODE_PLUS && in_char == CH_PLUS) begin
      mode_next = MODE_IDLE;
      tok0.kind = KIND_PLUSPLUS;
      cnt       = 2'd1;
    end else if (mode == MODE_EQ && in_char == CH_EQ) begin
      mode_next = MODE_IDLE;
      tok0.kind = KIND_EQEQ;
      cnt       = 2'd1;
    end else begin
      // close the pending token, then open on this character
      mode_next = MODE_IDLE;
      for (int i = 0; i < NAME_CHARS_KEPT; i++) nbuf_next[i] = 8'd0;
      nlen_next = 4'd0;
      acc_next  = 32'd0;
      if (flush_vld) begin
        tok0 = flush_tok;
        cnt  = 2'd1;
      end
      if (is_space(in_char)) begin
        mode_next = MODE_IDLE;
      end else if (is_alpha(in_char)) begin
        mode_next    = MODE_IDENT;
        nbuf_next[0] = in_char;
        nlen_next    = 4'd1;
      end else if (is_digit(in_char)) begin
        mode_next = MODE_NUMBER;
        acc_next  = {24'd0, in_char - CH_ZERO};
      end else if (in_char == CH_PLUS) begin
        mode_next = MODE_PLUS;
      end else if (in_char == CH_EQ) begin
        mode_next = MODE_EQ;
      end else begin
        if (sk == KIND_ERROR) mode_next = MODE_ERROR;
        if (cnt == 2'd0) tok0 = start_tok;
        else             tok1 = start_tok;
        cnt = cnt + 2'd1;
      end
    end
    if (cnt == 2'd1) tok0.last = 1'b1;
    if (cnt == 2'd2) tok1.last = 1'b1;
  end

  // results only count on an accepted word
  always_comb begin
    res.tok0  = tok0;
    res.tok1  = tok1;
    res.count = in_fire ? cnt : 2'd0;
  end

  // lexer state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      for (int i = 0; i < NAME_CHARS_KEPT; i++) nbuf[i] <= 8'd0;
      nlen <= 4'd0;
      acc  <= 32'd0;
    end else if (in_fire) begin
      mode <= mode_next;
      nbuf <= nbuf_next;
      nlen <= nlen_next;
      acc  <= acc_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/cslex_outq.sv -----
// ----------------------------------------------------------------------------
// cslex_outq
// Small shifting result queue, takes up to two tokens a cycle, gives one while out_ready is high
// ----------------------------------------------------------------------------
`default_nettype none

module cslex_outq (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  cslex_pkg::cslex_res_t     push,
  output logic                      room,
  output cslex_pkg::token_t         out_tok,
  output logic                      out_valid,
  input  wire logic                 out_ready
);
  import cslex_pkg::*;

  localparam int IdxW = $clog2(OUTQ_DEPTH);
  localparam int CntW = $clog2(OUTQ_DEPTH + 1);

  token_t          q [OUTQ_DEPTH];
  token_t          q_next [OUTQ_DEPTH];
  logic [CntW-1:0] count, count_next;
  logic [CntW-1:0] base;
  logic            pop;

  assign out_valid = (count != '0);
  assign out_tok   = q[0];
  assign pop       = out_valid && out_ready;
  // space for the two tokens one word may cause
  assign room      = (count <= CntW'(OUTQ_DEPTH - 2));

  // shift out head, then append new tokens behind what stays
  always_comb begin
    q_next = q;
    if (pop) begin
      for (int i = 0; i < OUTQ_DEPTH - 1; i++) q_next[i] = q[i + 1];
    end
    base = count - CntW'(pop);
    if (push.count != 2'd0) q_next[base[IdxW-1:0]] = push.tok0;
    if (push.count == 2'd2) q_next[IdxW'(base + CntW'(1))] = push.tok1;
    count_next = base + CntW'(push.count);
  end

  // queue storage
  always_ff @(posedge clk) begin
    q <= q_next;
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/c_subset_lexer.sv -----
// ----------------------------------------------------------------------------
// c_subset_lexer
// Streaming lexer for a small C subset, one source character per word
//
//   channel  dir  fields
//   s_axis   in   tdata[7:0] char_code, tlast end_of_source
//   m_axis   out  tuser token_kind, tdata value/chars/length, tlast last_of_run
//
// One character word is accepted per cycle while the result queue has room
// for two tokens. A token reaches m_axis through the input register, then
// the result queue. A word giving two tokens is offered as two output
// words; the four-entry queue absorbs this. Reset clears the lexer mode,
// name and number state and empties the queue. Stalls on m_axis hold the
// queue and back up into s_axis tready.
// ----------------------------------------------------------------------------
`default_nettype none

module c_subset_lexer #(
  parameter int NAME_CHARS_KEPT = cslex_pkg::NAME_CHARS_KEPT_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [7:0]                     s_axis_tdata,  // [7:0] char_code
  input  wire logic                           s_axis_tlast,  // end_of_source
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [31:0] token_value, [95:32] name_chars, [99:96] name_length, rest zero
  output logic [cslex_pkg::TDATA_W-1:0]       m_axis_tdata,
  output logic [4:0]                          m_axis_tuser,  // [4:0] token_kind
  output logic                                m_axis_tlast   // last_of_run
);
  import cslex_pkg::*;

  logic       in_vld;
  logic [7:0] in_char;
  logic       in_end;
  logic       room;
  logic       fire;
  cslex_res_t res;
  token_t     out_tok;

  assign fire          = in_vld && room;
  assign s_axis_tready = !in_vld || room;

  // input word register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_vld <= 1'b1;
    end else if (fire) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char <= s_axis_tdata;
      in_end  <= s_axis_tlast;
    end
  end

  // token decode and lexer state
  cslex_core #(
    .NAME_CHARS_KEPT (NAME_CHARS_KEPT)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .in_fire (fire),
    .in_char (in_char),
    .in_end  (in_end),
    .res     (res)
  );

  // result queue
  cslex_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (res),
    .room      (room),
    .out_tok   (out_tok),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready)
  );

  // output word packing
  assign m_axis_tdata = {4'd0, out_tok.length, out_tok.chars, out_tok.value};
  assign m_axis_tuser = out_tok.kind;
  assign m_axis_tlast = out_tok.last;

endmodule

`default_nettype wire

// ----- hdl/cslex_checker.sv -----
// ----------------------------------------------------------------------------
// cslex_checker
// Port-level checks on the lexer token stream
// ----------------------------------------------------------------------------
`default_nettype none

`include "c_subset_lexer_defines.svh"

module cslex_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      m_axis_tvalid,
  input wire logic                      m_axis_tready,
  input wire logic [cslex_pkg::TDATA_W-1:0] m_axis_tdata,
  input wire logic [4:0]                m_axis_tuser,
  input wire logic                      m_axis_tlast
);
  import cslex_pkg::*;

  // stalled token word holds
  `CSLEX_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled token changed")

  // eof always closes the run of its word
  `CSLEX_ASSERT_IMP(a_eof_last, m_axis_tvalid && m_axis_tuser == KIND_EOF, m_axis_tlast, "eof token without tlast")

  // name text only travels with identifier tokens
  `CSLEX_ASSERT_IMP(a_name_ident, m_axis_tvalid && m_axis_tuser != KIND_IDENT, m_axis_tdata[TDATA_W-1:32] == '0, "name text on non-identifier token")

  // kind code stays within the defined set
  `CSLEX_ASSERT_IMP(a_kind_range, m_axis_tvalid, m_axis_tuser <= KIND_ERROR, "undefined token kind")

endmodule

bind c_subset_lexer cslex_checker u_cslex_checker (.*);

`default_nettype wire
